// ===== src/mavg_pkg.sv =====
package mavg_pkg;

  localparam int unsigned SAMPLE_W       = 16;
  localparam int unsigned CFG_W          = 5;
  localparam int unsigned MAX_WINDOW_DEF = 20;
  localparam int unsigned WINDOW_RESET   = 3;

  // job queue between front and divider
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned QPTR_W  = $clog2(Q_DEPTH);
  localparam int unsigned QCNT_W  = $clog2(Q_DEPTH + 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [CFG_W-1:0]    cfg_t;

endpackage

// ===== src/mavg_front.sv =====
module mavg_front #(
  parameter int unsigned MAX_WINDOW = mavg_pkg::MAX_WINDOW_DEF,
  parameter int unsigned CNT_W      = $clog2(MAX_WINDOW + 1),
  parameter int unsigned SUM_W      = mavg_pkg::SAMPLE_W + CNT_W
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mavg_pkg::sample_t       sample_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    cfg_we_i,
  input  mavg_pkg::cfg_t          cfg_wdata_i,
  output logic signed [SUM_W-1:0] job_sum_o,
  output logic [CNT_W-1:0]        job_count_o,
  output logic                    job_full_o,
  output logic                    job_valid_o,
  input  logic                    job_ready_i
);
  import mavg_pkg::*;

  localparam int unsigned PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned RESET_WIN =
    (WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RESET;

  logic [CNT_W-1:0]        window_q, window_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [PTR_W-1:0]        pos_q, pos_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  sample_t                 ring_q [MAX_WINDOW];

  logic                    accept;
  logic                    at_full;
  logic signed [SUM_W-1:0] new_ext, old_ext;
  logic [CNT_W-1:0]        pos_inc;

  assign in_ready_o = job_ready_i;
  assign accept     = in_valid_i && job_ready_i;
  assign at_full    = (count_q == window_q);
  assign new_ext    = SUM_W'(sample_i);
  assign old_ext    = at_full ? SUM_W'(ring_q[pos_q]) : '0;
  assign pos_inc    = CNT_W'(pos_q) + CNT_W'(1);

  always_comb begin
    window_d = window_q;
    count_d  = count_q;
    pos_d    = pos_q;
    sum_d    = sum_q;
    if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        window_d = CNT_W'(1);
      end else if (32'(cfg_wdata_i) > MAX_WINDOW) begin
        window_d = CNT_W'(MAX_WINDOW);
      end else begin
        window_d = CNT_W'(cfg_wdata_i);
      end
      count_d = '0;
      pos_d   = '0;
      sum_d   = '0;
    end else if (accept) begin
      count_d = at_full ? count_q : count_q + CNT_W'(1);
      sum_d   = sum_q - old_ext + new_ext;
      pos_d   = (pos_inc >= window_q) ? '0 : PTR_W'(pos_inc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= CNT_W'(RESET_WIN);
      count_q  <= '0;
      pos_q    <= '0;
      sum_q    <= '0;
    end else begin
      window_q <= window_d;
      count_q  <= count_d;
      pos_q    <= pos_d;
      sum_q    <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !cfg_we_i) begin
      ring_q[pos_q] <= sample_i;
    end
  end

  assign job_valid_o = in_valid_i;
  assign job_sum_o   = sum_d;
  assign job_count_o = count_d;
  assign job_full_o  = (count_d == window_q);

  a_count_le_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= window_q)
    else $error("sample count above window size");

  a_pos_in_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(pos_q) < window_q)
    else $error("write position outside window");

  a_window_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (window_q != '0) && (32'(window_q) <= MAX_WINDOW))
    else $error("window size out of range");

endmodule

// ===== src/mavg_queue.sv =====
module mavg_queue #(
  parameter int unsigned DATA_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              wvalid_i,
  output logic              wready_o,
  output logic [DATA_W-1:0] rdata_o,
  output logic              rvalid_o,
  input  logic              rready_i
);
  import mavg_pkg::*;

  logic [DATA_W-1:0] mem_q [Q_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              push, pop;

  assign wready_o = (cnt_q != QCNT_W'(Q_DEPTH));
  assign rvalid_o = (cnt_q != '0);
  assign rdata_o  = mem_q[rptr_q];
  assign push     = wvalid_i && wready_o;
  assign pop      = rvalid_o && rready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (32'(wptr_q) == Q_DEPTH - 1) ? '0 : wptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rptr_q <= (32'(rptr_q) == Q_DEPTH - 1) ? '0 : rptr_q + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= Q_DEPTH)
    else $error("queue count above depth");

endmodule

// ===== src/mavg_div.sv =====
module mavg_div #(
  parameter int unsigned CNT_W = 5,
  parameter int unsigned SUM_W = 21
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic signed [SUM_W-1:0] job_sum_i,
  input  logic [CNT_W-1:0]        job_count_i,
  input  logic                    job_full_i,
  input  logic                    job_valid_i,
  output logic                    job_ready_o,
  output mavg_pkg::sample_t       average_o,
  output logic                    window_full_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i
);
  import mavg_pkg::*;

  localparam int unsigned STEP_W = $clog2(SUM_W);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SUM_W-1:0]  dvd_q, dvd_d;
  logic [CNT_W:0]    rem_q, rem_d;
  logic [CNT_W-1:0]  div_q, div_d;
  logic              neg_q, neg_d;
  logic              full_q, full_d;
  logic              out_valid_q, out_valid_d;
  sample_t           avg_q, avg_d;
  logic              wfull_q, wfull_d;

  logic [CNT_W:0]    rem_sh;
  logic              ge;
  logic [SUM_W-1:0]  quot;

  assign rem_sh = {rem_q[CNT_W-1:0], dvd_q[SUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, div_q});
  assign quot   = neg_q ? (~dvd_q + SUM_W'(1)) : dvd_q;

  assign job_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    div_d       = div_q;
    neg_d       = neg_q;
    full_d      = full_q;
    out_valid_d = out_valid_q;
    avg_d       = avg_q;
    wfull_d     = wfull_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          neg_d   = job_sum_i[SUM_W-1];
          dvd_d   = job_sum_i[SUM_W-1] ? SUM_W'(-job_sum_i) : SUM_W'(job_sum_i);
          rem_d   = '0;
          div_d   = job_count_i;
          full_d  = job_full_i;
          step_d  = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        rem_d  = ge ? (rem_sh - {1'b0, div_q}) : rem_sh;
        dvd_d  = {dvd_q[SUM_W-2:0], ge};
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(SUM_W - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          avg_d       = sample_t'(quot[SAMPLE_W-1:0]);
          wfull_d     = full_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
    div_q   <= div_d;
    neg_q   <= neg_d;
    full_q  <= full_d;
    avg_q   <= avg_d;
    wfull_q <= wfull_d;
  end

  assign average_o     = avg_q;
  assign window_full_o = wfull_q;
  assign out_valid_o   = out_valid_q;

  a_divisor_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (div_q != '0))
    else $error("divide by zero count");

  a_rem_below_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (rem_q < {1'b0, div_q}))
    else $error("remainder not below divisor");

endmodule

// ===== src/moving_average_window.sv =====
// moving average over the last N signed 16-bit samples
// input channel: sample_i with in_valid_i / in_ready_o, one word per sample
// output channel: average_o and window_full_o with out_valid_o / out_ready_i,
//   exactly one word per accepted sample, in order
// config: cfg_we_i writes cfg_wdata_i as window size (clamped to 1..MAX_WINDOW)
//   and clears the history; write only while no sample is in flight
// front: updates ring, count and running sum in the accept cycle and queues
//   the job (two entries); back: restoring divider, one quotient bit per cycle
// the divider works on one job at a time and takes the next only once its result
//   is in the output register; the queue holds the jobs behind it; the divider is
//   bit-serial over SUM_W bits, SUM_W = 16 + clog2(MAX_WINDOW + 1)
// reset: window size 3, empty history, queue and output empty
// a stalled receiver holds the result in the output register; the divider
//   finishes the next job and the queue takes two more samples before
//   in_ready_o drops
module moving_average_window #(
  parameter int unsigned MAX_WINDOW = mavg_pkg::MAX_WINDOW_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mavg_pkg::sample_t sample_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output mavg_pkg::sample_t average_o,
  output logic              window_full_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  logic              cfg_we_i,
  input  mavg_pkg::cfg_t    cfg_wdata_i
);
  import mavg_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SUM_W  = SAMPLE_W + CNT_W;
  localparam int unsigned JOB_W  = SUM_W + CNT_W + 1;

  logic signed [SUM_W-1:0] f_sum;
  logic [CNT_W-1:0]        f_count;
  logic                    f_full, f_valid, f_ready;
  logic [JOB_W-1:0]        q_rdata;
  logic                    q_valid, q_ready;

  mavg_front #(
    .MAX_WINDOW (MAX_WINDOW),
    .CNT_W      (CNT_W),
    .SUM_W      (SUM_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .job_sum_o   (f_sum),
    .job_count_o (f_count),
    .job_full_o  (f_full),
    .job_valid_o (f_valid),
    .job_ready_i (f_ready)
  );

  mavg_queue #(
    .DATA_W (JOB_W)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wdata_i  ({f_sum, f_count, f_full}),
    .wvalid_i (f_valid),
    .wready_o (f_ready),
    .rdata_o  (q_rdata),
    .rvalid_o (q_valid),
    .rready_i (q_ready)
  );

  mavg_div #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W)
  ) u_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_sum_i     (q_rdata[JOB_W-1 -: SUM_W]),
    .job_count_i   (q_rdata[CNT_W:1]),
    .job_full_i    (q_rdata[0]),
    .job_valid_i   (q_valid),
    .job_ready_o   (q_ready),
    .average_o     (average_o),
    .window_full_o (window_full_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i)
  );

endmodule

// ===== tb/moving_average_window_tb.sv =====
module moving_average_window_tb;

  import mavg_pkg::*;

  localparam int unsigned MaxWin = MAX_WINDOW_DEF;

  typedef struct packed {
    sample_t average;
    logic    full;
  } avg_word_t;

  logic    clk_i         = 1'b0;
  logic    rst_ni        = 1'b0;
  sample_t sample_i      = '0;
  logic    in_valid_i    = 1'b0;
  logic    in_ready_o;
  sample_t average_o;
  logic    window_full_o;
  logic    out_valid_o;
  logic    out_ready_i   = 1'b0;
  logic    cfg_we_i      = 1'b0;
  cfg_t    cfg_wdata_i   = '0;

  // predictor state
  sample_t   hist_ring [MaxWin];
  int        hist_pos;
  int        hist_held;
  int        hist_sum;
  int        win_size;
  avg_word_t pending_averages[$];

  int send_idle_pct;
  int recv_stall_pct;
  int error_count;

  moving_average_window i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sample_i      (sample_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .average_o     (average_o),
    .window_full_o (window_full_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic void clear_history();
    hist_pos  = 0;
    hist_held = 0;
    hist_sum  = 0;
  endfunction

  function automatic void apply_window_size(input cfg_t v);
    if (v == 0) begin
      win_size = 1;
    end else if (v > MaxWin) begin
      win_size = MaxWin;
    end else begin
      win_size = int'(v);
    end
    clear_history();
  endfunction

  function automatic avg_word_t predict_average(input sample_t s);
    avg_word_t w;
    int        pos;
    pos = hist_pos;
    if (pos >= MaxWin) pos = 0;
    if (hist_held < win_size) begin
      hist_held++;
    end else begin
      hist_sum -= hist_ring[pos];
    end
    hist_ring[pos] = s;
    hist_sum += s;
    pos++;
    if (pos >= win_size) pos = 0;
    hist_pos  = pos;
    w.average = sample_t'(hist_sum / hist_held);
    w.full    = (hist_held == win_size);
    return w;
  endfunction

  function automatic sample_t random_sample();
    case ($urandom_range(0, 7))
      0:       return sample_t'(16'h7fff);
      1:       return sample_t'(16'h8000);
      2:       return sample_t'(int'($urandom_range(0, 15)) - 8);
      default: return sample_t'($urandom_range(0, 65535));
    endcase
  endfunction

  // receiver stalls
  always @(negedge clk_i) begin
    out_ready_i <= (int'($urandom_range(0, 99)) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    avg_word_t exp_w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_averages.size() == 0) begin
        $display("%0t: unexpected word, actual average %0d full %0b",
                 $time, average_o, window_full_o);
        error_count++;
      end else begin
        exp_w = pending_averages.pop_front();
        if (average_o !== exp_w.average) begin
          $display("%0t: average mismatch, expected %0d actual %0d",
                   $time, exp_w.average, average_o);
          error_count++;
        end
        if (window_full_o !== exp_w.full) begin
          $display("%0t: window_full mismatch, expected %0b actual %0b",
                   $time, exp_w.full, window_full_o);
          error_count++;
        end
      end
    end
  end

  task automatic send_sample(input sample_t s);
    @(negedge clk_i);
    while (int'($urandom_range(0, 99)) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    sample_i   = s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_averages.push_back(predict_average(s));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_averages.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_window(input cfg_t v);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    apply_window_size(v);
  endtask

  task automatic test_reset_window();
    send_sample(sample_t'(16'h7fff));
    send_sample(sample_t'(16'h7fff));
    send_sample(sample_t'(16'h8000));
    send_sample(sample_t'(16'h8000));
    send_sample(sample_t'(-1));
  endtask

  task automatic test_window_extremes();
    // zero clamps to one
    write_window(cfg_t'(0));
    send_sample(sample_t'(16'h7fff));
    send_sample(sample_t'(16'h8000));
    send_sample(sample_t'(1));
    // all ones clamps to the maximum
    write_window(cfg_t'(31));
    send_sample(sample_t'(16'h8000));
    send_sample(sample_t'(16'h7fff));
    send_sample(sample_t'(-2));
    write_window(cfg_t'(1));
    send_sample(sample_t'(-7));
    send_sample(sample_t'(5));
    // truncation toward zero on a negative sum
    write_window(cfg_t'(2));
    send_sample(sample_t'(-3));
    send_sample(sample_t'(0));
    send_sample(sample_t'(3));
    write_window(cfg_t'(MaxWin));
    send_sample(sample_t'(16'h5555));
    send_sample(sample_t'(16'haaaa));
  endtask

  task automatic test_sender_pause();
    write_window(cfg_t'(4));
    repeat (6) send_sample(random_sample());
    wait_drained();
    repeat (6) send_sample(random_sample());
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n_items);
    int sent;
    int seg_len;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      write_window(cfg_t'($urandom_range(0, 31)));
      seg_len = $urandom_range(5, 60);
      repeat (seg_len) send_sample(random_sample());
      sent += seg_len;
    end
  endtask

  initial begin : timeout_guard
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    error_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < MaxWin; i++) hist_ring[i] = '0;
    apply_window_size(cfg_t'(WINDOW_RESET));
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_window();
    test_window_extremes();
    test_sender_pause();
    test_random_phase(0, 0, 250);
    test_random_phase(51, 0, 250);
    test_random_phase(0, 51, 250);
    test_random_phase(31, 31, 250);

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
